// ===== hw/rtl/tlv_pkg.sv =====
// tlv_pkg: shared constants and types for the record store
// no dependencies
package tlv_pkg;
  localparam int BUFFER_BYTES = 1024;
  localparam int STAGE_BYTES = 256;

  localparam int KIND_W = 3;
  localparam int TAG_W = 32;
  localparam int LEN_W = 16;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 8;
  localparam int STATUS_W = 3;
  localparam int SIZE_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0] K_LOAD = 3'd0;
  localparam logic [KIND_W-1:0] K_VALIDATE = 3'd1;
  localparam logic [KIND_W-1:0] K_LOOKUP = 3'd2;
  localparam logic [KIND_W-1:0] K_ADD = 3'd3;
  localparam logic [KIND_W-1:0] K_UPDATE = 3'd4;
  localparam logic [KIND_W-1:0] K_DELETE = 3'd5;
  localparam logic [KIND_W-1:0] K_STAGE = 3'd6;
  localparam logic [KIND_W-1:0] K_READ = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CORRUPTED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TAG = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] value_length;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0] value_offset;
    logic [LEN_W-1:0] found_length;
    logic [SIZE_W-1:0] used_size;
    logic [DATA_W-1:0] read_data;
  } rsp_t;
endpackage

// ===== hw/rtl/tlv_if.sv =====
// tlv_req_if / tlv_rsp_if: valid-ready channels for items
// depends on tlv_pkg
interface tlv_req_if;
  import tlv_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tlv_rsp_if;
  import tlv_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tlv_record_store.sv =====
// tlv_record_store: byte buffer of packed tag-length-value records
// depends on tlv_pkg, tlv_if (tlv_req_if, tlv_rsp_if), tlv_byte_ram
//
// channel  dir  handshake     payload
// req      in   valid/ready   kind, tag, value_length, address, data
// rsp      out  valid/ready   status, value_offset, found_length, used_size, read_data
// cfg      in   cfg_we        cfg_index, cfg_data
//
// one item at a time; ready only in idle with the result register empty
// load and stage write in the done state; read captures the registered buffer byte;
// a search reads each header byte by byte; moves copy one byte at a time on the
// single buffer port; header bytes are written directly, value bytes via the staging ram
// rst clears control state and bytes_used; memories are not cleared
module tlv_record_store (
  input logic clk,
  input logic rst,
  tlv_req_if.sink req,
  tlv_rsp_if.source rsp,
  input logic cfg_we,
  input logic [tlv_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [tlv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlv_pkg::*;

  localparam int BA = $clog2(BUFFER_BYTES);
  localparam int SA = (STAGE_BYTES > 1) ? $clog2(STAGE_BYTES) : 1;
  localparam int PW = 18;
  localparam logic [PW-1:0] HDR = PW'(6);
  localparam logic [PW-1:0] BUFN = PW'(BUFFER_BYTES);
  localparam logic [PW-1:0] STGN = PW'(STAGE_BYTES);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_HRD = 5'd1;
  localparam logic [4:0] S_HWAIT = 5'd2;
  localparam logic [4:0] S_HCAP = 5'd3;
  localparam logic [4:0] S_HEVAL = 5'd4;
  localparam logic [4:0] S_DECIDE = 5'd5;
  localparam logic [4:0] S_MRD = 5'd6;
  localparam logic [4:0] S_MWAIT = 5'd7;
  localparam logic [4:0] S_MWR = 5'd8;
  localparam logic [4:0] S_HWR = 5'd9;
  localparam logic [4:0] S_VRD = 5'd10;
  localparam logic [4:0] S_VWAIT = 5'd11;
  localparam logic [4:0] S_VWR = 5'd12;
  localparam logic [4:0] S_DONE = 5'd13;
  localparam logic [4:0] S_RDWAIT = 5'd14;
  localparam logic [4:0] S_RDCAP = 5'd15;
  localparam logic [4:0] S_VALEND = 5'd16;

  logic [4:0] state;
  logic [SIZE_W-1:0] capacity;
  logic [TAG_W-1:0] end_tag;
  logic [SIZE_W-1:0] bytes_used;
  req_t cur;
  logic [PW-1:0] off, pos, cnt, src, dst, mlen, old_len;
  logic [2:0] hidx;
  logic [TAG_W-1:0] htag;
  logic [LEN_W-1:0] hlen;
  logic found;
  logic tail_move;
  logic [1:0] after;
  logic rsp_valid;
  rsp_t rsp_q;

  logic buf_we;
  logic [BA-1:0] buf_addr;
  logic [7:0] buf_wdata, buf_rdata;
  logic stg_we;
  logic [SA-1:0] stg_addr;
  logic [7:0] stg_rdata;

  tlv_byte_ram #(.DEPTH(BUFFER_BYTES), .AW(BA)) u_buf (
    .clk(clk), .we(buf_we), .addr(buf_addr), .wdata(buf_wdata), .rdata(buf_rdata)
  );
  tlv_byte_ram #(.DEPTH(STAGE_BYTES), .AW(SA)) u_stg (
    .clk(clk), .we(stg_we), .addr(stg_addr), .wdata(cur.data), .rdata(stg_rdata)
  );

  logic [PW-1:0] cap_eff, used_w, len_w;
  assign cap_eff = ({7'd0, capacity} > BUFN) ? BUFN : {7'd0, capacity};
  assign used_w = {7'd0, bytes_used};
  assign len_w = {2'd0, cur.value_length};
  logic is_val;
  assign is_val = (cur.kind == K_VALIDATE);

  // header byte at hidx for the write of header fields
  logic [7:0] hbyte;
  always_comb begin
    case (hidx)
      3'd0: hbyte = cur.tag[7:0];
      3'd1: hbyte = cur.tag[15:8];
      3'd2: hbyte = cur.tag[23:16];
      3'd3: hbyte = cur.tag[31:24];
      3'd4: hbyte = cur.value_length[7:0];
      3'd5: hbyte = cur.value_length[15:8];
      default: hbyte = 8'd0;
    endcase
  end

  always_comb begin
    buf_we = 1'b0;
    buf_addr = '0;
    buf_wdata = cur.data;
    stg_we = 1'b0;
    stg_addr = cur.address[SA-1:0];
    unique case (state)
      S_IDLE: begin
        buf_addr = cur.address[BA-1:0];
      end
      S_HRD: buf_addr = BA'(off + {15'd0, hidx});
      S_MRD: buf_addr = BA'(src);
      S_MWAIT: buf_addr = BA'(src);
      S_MWR: begin
        buf_we = 1'b1;
        buf_addr = BA'(dst);
        buf_wdata = buf_rdata;
      end
      S_HWR: begin
        buf_we = 1'b1;
        buf_addr = BA'(pos + {15'd0, hidx});
        buf_wdata = hbyte;
      end
      S_VRD: stg_addr = SA'(cnt);
      S_VWAIT: stg_addr = SA'(cnt);
      S_VWR: begin
        buf_we = 1'b1;
        buf_addr = BA'(pos + HDR + cnt);
        buf_wdata = stg_rdata;
      end
      S_DONE: begin
        buf_we = (cur.kind == K_LOAD);
        buf_addr = cur.address[BA-1:0];
        stg_we = (cur.kind == K_STAGE);
      end
      default: buf_addr = cur.address[BA-1:0];
    endcase
  end

  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.payload = rsp_q;

  logic bad_len;
  assign bad_len = (len_w == '0) || (len_w > STGN);
  logic [PW-1:0] rec_end;
  assign rec_end = pos + HDR + old_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= SIZE_W'(1024);
      end_tag <= '1;
      bytes_used <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) capacity <= cfg_data[SIZE_W-1:0];
        else end_tag <= cfg_data;
      end
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.payload;
            rsp_q <= '0;
            off <= '0;
            hidx <= '0;
            found <= 1'b0;
            if (req.payload.kind == K_READ) state <= S_RDWAIT;
            else if (req.payload.kind == K_LOAD || req.payload.kind == K_STAGE)
              state <= S_DONE;
            else state <= S_HCAP;
          end
        end
        S_HCAP: begin
          // loop head: check the header fits
          hidx <= '0;
          if (is_val) begin
            if (off >= cap_eff) begin
              bytes_used <= SIZE_W'(off);
              state <= S_DONE;
            end else if (off + HDR > cap_eff) begin
              bytes_used <= '0;
              if (off != '0) rsp_q.status <= ST_CORRUPTED;
              state <= S_DONE;
            end else state <= S_HRD;
          end else begin
            if (off + HDR > used_w) state <= S_DECIDE;
            else state <= S_HRD;
          end
        end
        S_HRD: state <= S_HWAIT;
        S_HWAIT: begin
          case (hidx)
            3'd0: htag[7:0] <= buf_rdata;
            3'd1: htag[15:8] <= buf_rdata;
            3'd2: htag[23:16] <= buf_rdata;
            3'd3: htag[31:24] <= buf_rdata;
            3'd4: hlen[7:0] <= buf_rdata;
            default: hlen[15:8] <= buf_rdata;
          endcase
          if (hidx == 3'd5) state <= S_HEVAL;
          else begin
            hidx <= hidx + 3'd1;
            state <= S_HRD;
          end
        end
        S_HEVAL: begin
          if (is_val) begin
            if (htag == end_tag) begin
              bytes_used <= SIZE_W'(off);
              state <= S_DONE;
            end else if (off + HDR + {2'd0, hlen} > cap_eff) begin
              bytes_used <= '0;
              rsp_q.status <= ST_CORRUPTED;
              state <= S_DONE;
            end else begin
              off <= off + HDR + {2'd0, hlen};
              state <= S_HCAP;
            end
          end else if (htag == end_tag) state <= S_DECIDE;
          else if (htag == cur.tag) begin
            found <= 1'b1;
            pos <= off;
            old_len <= {2'd0, hlen};
            state <= S_DECIDE;
          end else begin
            off <= off + HDR + {2'd0, hlen};
            state <= S_HCAP;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          hidx <= '0;
          cnt <= '0;
          unique case (cur.kind)
            K_LOOKUP: begin
              if (!found) rsp_q.status <= ST_NOT_FOUND;
              else if (rec_end > used_w) rsp_q.status <= ST_CORRUPTED;
              else begin
                rsp_q.found_length <= old_len[LEN_W-1:0];
                rsp_q.value_offset <= (old_len != '0) ? SIZE_W'(pos + HDR) : '0;
              end
            end
            K_ADD: begin
              if (bad_len || cur.tag == end_tag) rsp_q.status <= ST_INVALID;
              else if (found) rsp_q.status <= ST_DUPLICATE;
              else if (used_w + HDR + len_w > cap_eff) rsp_q.status <= ST_NO_SPACE;
              else begin
                pos <= used_w;
                bytes_used <= SIZE_W'(used_w + HDR + len_w);
                state <= S_HWR;
              end
            end
            K_UPDATE: begin
              if (bad_len) rsp_q.status <= ST_INVALID;
              else if (!found) rsp_q.status <= ST_NOT_FOUND;
              else if (rec_end > used_w) rsp_q.status <= ST_CORRUPTED;
              else if (len_w == old_len) state <= S_VRD;
              else if (len_w < old_len) begin
                // header, value, then pull the tail down
                src <= pos + HDR + old_len;
                dst <= pos + HDR + len_w;
                mlen <= used_w - (pos + HDR + old_len);
                tail_move <= 1'b0;
                bytes_used <= SIZE_W'(used_w - (old_len - len_w));
                state <= S_HWR;
              end else if (used_w + (len_w - old_len) > cap_eff)
                rsp_q.status <= ST_NO_SPACE;
              else begin
                // push the tail up first, from the top down
                mlen <= used_w - rec_end;
                src <= used_w - PW'(1);
                dst <= used_w - PW'(1) + (len_w - old_len);
                tail_move <= 1'b1;
                bytes_used <= SIZE_W'(used_w + (len_w - old_len));
                after <= 2'd1;
                state <= (used_w > rec_end) ? S_MRD : S_HWR;
              end
            end
            K_DELETE: begin
              if (!found) rsp_q.status <= ST_NOT_FOUND;
              else if (rec_end > used_w) rsp_q.status <= ST_CORRUPTED;
              else begin
                src <= rec_end;
                dst <= pos;
                mlen <= used_w - rec_end;
                tail_move <= 1'b0;
                after <= 2'd0;
                bytes_used <= SIZE_W'(used_w - HDR - old_len);
                state <= (used_w > rec_end) ? S_MRD : S_DONE;
              end
            end
            default: ;
          endcase
        end
        S_HWR: begin
          if (hidx == 3'd5) begin
            cnt <= '0;
            state <= S_VRD;
          end else hidx <= hidx + 3'd1;
        end
        S_VRD: state <= S_VWAIT;
        S_VWAIT: state <= S_VWR;
        S_VWR: begin
          if (cnt + PW'(1) == len_w) begin
            if (cur.kind == K_UPDATE && len_w < old_len && mlen != '0) begin
              after <= 2'd0;
              state <= S_MRD;
            end else state <= S_DONE;
          end else begin
            cnt <= cnt + PW'(1);
            state <= S_VRD;
          end
        end
        S_MRD: state <= S_MWAIT;
        S_MWAIT: state <= S_MWR;
        S_MWR: begin
          if (mlen == PW'(1)) begin
            hidx <= '0;
            state <= (after == 2'd1) ? S_HWR : S_DONE;
          end else begin
            mlen <= mlen - PW'(1);
            if (tail_move) begin
              src <= src - PW'(1);
              dst <= dst - PW'(1);
            end else begin
              src <= src + PW'(1);
              dst <= dst + PW'(1);
            end
            state <= S_MRD;
          end
        end
        S_RDWAIT: state <= S_RDCAP;
        S_RDCAP: begin
          rsp_q.read_data <= buf_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          rsp_q.used_size <= bytes_used;
          rsp_valid <= 1'b1;
          state <= S_VALEND;
        end
        S_VALEND: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && rsp_valid) begin
      assert (state == S_IDLE || state == S_VALEND)
        else $error("result pending while an item is at work");
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !req.ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

  property p_used_in_buf;
    @(posedge clk) disable iff (rst) {7'd0, bytes_used} <= BUFN;
  endproperty
  a_used_in_buf: assert property (p_used_in_buf) else $error("bytes_used past buffer");

  property p_status_range;
    @(posedge clk) disable iff (rst) rsp_valid |-> rsp_q.status <= ST_CORRUPTED;
  endproperty
  a_status_range: assert property (p_status_range) else $error("bad status");
endmodule

// ===== hw/rtl/tlv_byte_ram.sv =====
// tlv_byte_ram: single-port byte memory with registered read
// no package dependency
module tlv_byte_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input logic clk,
  input logic we,
  input logic [AW-1:0] addr,
  input logic [7:0] wdata,
  output logic [7:0] rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== tb/tlv_record_store_checker.sv =====
`timescale 1ns / 100ps
// tlv_record_store_checker: watches the item channels and register writes,
// predicts every response of the record store and compares field by field
// depends on tlv_pkg and tlv_if (tlv_req_if, tlv_rsp_if)
module tlv_record_store_checker
  import tlv_pkg::*;
(
  input logic clk,
  input logic rst,
  tlv_req_if req,
  tlv_rsp_if rsp,
  input logic cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  output int errors,
  output int pending,
  output int used_bytes,
  output int checked
);
  localparam int BUF_BYTES = 1024;
  localparam int STG_BYTES = 256;
  localparam int HDR_BYTES = 6;

  logic [7:0] rec_mem [BUF_BYTES];
  logic [7:0] stage_mem [STG_BYTES];
  int used;
  int cap_reg;
  logic [31:0] end_tag;
  rsp_t rsp_q [$];

  function automatic int eff_cap();
    return (cap_reg > BUF_BYTES) ? BUF_BYTES : cap_reg;
  endfunction

  function automatic int mem_at(int p);
    return int'(rec_mem[p % BUF_BYTES]);
  endfunction

  function automatic logic [31:0] tag_at(int p);
    return {rec_mem[(p + 3) % BUF_BYTES], rec_mem[(p + 2) % BUF_BYTES],
            rec_mem[(p + 1) % BUF_BYTES], rec_mem[p % BUF_BYTES]};
  endfunction

  function automatic int len_at(int p);
    return mem_at(p + 4) | (mem_at(p + 5) << 8);
  endfunction

  function automatic void write_header(int p, logic [31:0] t, int n);
    rec_mem[p % BUF_BYTES] = t[7:0];
    rec_mem[(p + 1) % BUF_BYTES] = t[15:8];
    rec_mem[(p + 2) % BUF_BYTES] = t[23:16];
    rec_mem[(p + 3) % BUF_BYTES] = t[31:24];
    rec_mem[(p + 4) % BUF_BYTES] = n[7:0];
    rec_mem[(p + 5) % BUF_BYTES] = n[15:8];
  endfunction

  function automatic void write_value(int p, int n);
    for (int i = 0; i < n; i++) rec_mem[(p + i) % BUF_BYTES] = stage_mem[i % STG_BYTES];
  endfunction

  function automatic void shift_tail(int dst, int src);
    int n;
    if (src < used && dst < BUF_BYTES && src < BUF_BYTES) begin
      n = used - src;
      if (dst + n > BUF_BYTES) n = BUF_BYTES - dst;
      if (dst < src) begin
        for (int i = 0; i < n; i++) rec_mem[dst + i] = rec_mem[src + i];
      end else begin
        for (int i = n - 1; i >= 0; i--) rec_mem[dst + i] = rec_mem[src + i];
      end
    end
  endfunction

  function automatic bit search_tag(logic [31:0] t, output int pos);
    int off;
    off = 0;
    pos = 0;
    while (off + HDR_BYTES <= used) begin
      if (tag_at(off) == end_tag) return 0;
      if (tag_at(off) == t) begin
        pos = off;
        return 1;
      end
      off += HDR_BYTES + len_at(off);
    end
    return 0;
  endfunction

  function automatic logic [STATUS_W-1:0] scan_list();
    int c;
    int off;
    int stop;
    c = eff_cap();
    off = 0;
    while (off < c) begin
      if (off + HDR_BYTES > c) begin
        used = 0;
        return (off == 0) ? ST_OK : ST_CORRUPTED;
      end
      if (tag_at(off) == end_tag) begin
        used = off;
        return ST_OK;
      end
      stop = off + HDR_BYTES + len_at(off);
      if (stop > c) begin
        used = 0;
        return ST_CORRUPTED;
      end
      off = stop;
    end
    used = off;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int pos;
    int old_len;
    int n;
    int vpos;
    bit hit;
    bit whole;
    o = '0;
    o.status = ST_OK;
    pos = 0;
    old_len = 0;
    hit = 0;
    whole = 0;
    n = int'(r.value_length);
    if (r.kind inside {K_LOOKUP, K_ADD, K_UPDATE, K_DELETE}) begin
      hit = search_tag(r.tag, pos);
      if (hit) begin
        old_len = len_at(pos);
        whole = (pos + HDR_BYTES + old_len <= used);
      end
    end
    vpos = pos + HDR_BYTES;
    case (r.kind)
      K_LOAD: rec_mem[r.address % BUF_BYTES] = r.data;
      K_VALIDATE: o.status = scan_list();
      K_LOOKUP: begin
        if (!hit) o.status = ST_NOT_FOUND;
        else if (!whole) o.status = ST_CORRUPTED;
        else begin
          o.found_length = old_len[LEN_W-1:0];
          o.value_offset = (old_len > 0) ? vpos[SIZE_W-1:0] : '0;
        end
      end
      K_ADD: begin
        if (n == 0 || n > STG_BYTES || r.tag == end_tag) o.status = ST_INVALID;
        else if (hit) o.status = ST_DUPLICATE;
        else if (used + HDR_BYTES + n > eff_cap()) o.status = ST_NO_SPACE;
        else begin
          write_header(used, r.tag, n);
          write_value(used + HDR_BYTES, n);
          used += HDR_BYTES + n;
        end
      end
      K_UPDATE: begin
        if (n == 0 || n > STG_BYTES) o.status = ST_INVALID;
        else if (!hit) o.status = ST_NOT_FOUND;
        else if (!whole) o.status = ST_CORRUPTED;
        else if (n == old_len) write_value(vpos, n);
        else if (n < old_len) begin
          write_header(pos, r.tag, n);
          write_value(vpos, n);
          shift_tail(vpos + n, vpos + old_len);
          used -= old_len - n;
        end else if (used + (n - old_len) > eff_cap()) o.status = ST_NO_SPACE;
        else begin
          shift_tail(vpos + n, vpos + old_len);
          write_header(pos, r.tag, n);
          write_value(vpos, n);
          used += n - old_len;
        end
      end
      K_DELETE: begin
        if (!hit) o.status = ST_NOT_FOUND;
        else if (!whole) o.status = ST_CORRUPTED;
        else begin
          shift_tail(pos, pos + HDR_BYTES + old_len);
          used -= HDR_BYTES + old_len;
        end
      end
      K_STAGE: stage_mem[r.address % STG_BYTES] = r.data;
      default: o.read_data = rec_mem[r.address % BUF_BYTES];
    endcase
    o.used_size = used[SIZE_W-1:0];
    return o;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      used = 0;
      cap_reg = 1024;
      end_tag = 32'hFFFF_FFFF;
      rsp_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) cap_reg = int'(cfg_data[SIZE_W-1:0]);
        else if (cfg_index == REG_END_TAG) end_tag = cfg_data;
      end
      if (req.valid && req.ready) rsp_q.push_back(predict_response(req.payload));
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          errors++;
          $display("%0t: response with no item outstanding, actual %p", $time, rsp.payload);
        end else begin
          want = rsp_q.pop_front();
          checked++;
          compare_field("status", want.status, rsp.payload.status);
          compare_field("value_offset", want.value_offset, rsp.payload.value_offset);
          compare_field("found_length", want.found_length, rsp.payload.found_length);
          compare_field("used_size", want.used_size, rsp.payload.used_size);
          compare_field("read_data", want.read_data, rsp.payload.read_data);
        end
      end
    end
    pending = rsp_q.size();
    used_bytes = used;
  end
endmodule

// ===== tb/tlv_record_store_test.sv =====
`timescale 1ns / 100ps
// tlv_record_store_test: drives record operations and register settings into
// the record store with random idling on both channels; the checker judges
// depends on tlv_pkg, tlv_if, tlv_record_store and tlv_record_store_checker
module tlv_record_store_test;
  import tlv_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors;
  int pending;
  int used_bytes;
  int checked;
  int sent = 0;
  bit no_idle = 0;
  logic [31:0] tag_pool [8];
  logic [31:0] cur_end_tag = 32'hFFFF_FFFF;
  int stall_left;

  tlv_req_if req_ch ();
  tlv_rsp_if rsp_ch ();

  tlv_record_store u_top (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tlv_record_store_checker u_checker (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .used_bytes(used_bytes), .checked(checked)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    rsp_ch.ready = 0;
    req_ch.valid = 0;
    req_ch.payload = '0;
  end

  always @(posedge clk) begin
    int s;
    if (rst) begin
      rsp_ch.ready <= 0;
      stall_left <= 0;
    end else if (rsp_ch.ready && rsp_ch.valid) begin
      s = draw_gap();
      if (s > 0) begin
        rsp_ch.ready <= 0;
        stall_left <= s - 1;
      end
    end else if (!rsp_ch.ready) begin
      if (stall_left == 0) rsp_ch.ready <= 1;
      else stall_left <= stall_left - 1;
    end
  end

  task automatic send_item(logic [KIND_W-1:0] k, logic [31:0] t, logic [15:0] n,
                           logic [9:0] a, logic [7:0] d);
    req_t r;
    int g;
    r.kind = k;
    r.tag = t;
    r.value_length = n;
    r.address = a;
    r.data = d;
    req_ch.valid <= 1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    g = draw_gap();
    if (g > 0) begin
      req_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == REG_END_TAG) cur_end_tag = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // accepted lengths stay within the staged value bytes 0..63
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(1, 24));
    if (r < 92) return 16'($urandom_range(25, 64));
    if (r < 96) return 16'd0;
    return 16'($urandom_range(257, 65535));
  endfunction

  function automatic logic [31:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return tag_pool[$urandom_range(0, 7)];
    if (r < 92) return cur_end_tag;
    return $urandom();
  endfunction

  task automatic random_ops(int count);
    int r;
    logic [9:0] a;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      a = 10'($urandom());
      if (r < 14) send_item(K_STAGE, $urandom(), 16'($urandom()), a, 8'($urandom()));
      else if (r < 34) send_item(K_ADD, pick_tag(), pick_len(), a, 8'($urandom()));
      else if (r < 48) send_item(K_LOOKUP, pick_tag(), 16'($urandom()), a, 8'($urandom()));
      else if (r < 64) send_item(K_UPDATE, pick_tag(), pick_len(), a, 8'($urandom()));
      else if (r < 74) send_item(K_DELETE, pick_tag(), 16'($urandom()), a, 8'($urandom()));
      else if (r < 82) send_item(K_READ, $urandom(), 16'($urandom()), a, 8'($urandom()));
      else if (r < 90) begin
        if (used_bytes > 0 && $urandom_range(0, 1) == 1)
          a = 10'($urandom_range(0, used_bytes - 1));
        send_item(K_LOAD, $urandom(), 16'($urandom()), a, 8'($urandom()));
      end else send_item(K_VALIDATE, $urandom(), 16'($urandom()), a, 8'($urandom()));
    end
  endtask

  initial begin
    tag_pool[0] = 32'h0000_0000;
    tag_pool[1] = 32'h0000_0001;
    tag_pool[2] = 32'h8000_0000;
    tag_pool[3] = 32'hFFFF_FFFE;
    for (int i = 4; i < 8; i++) tag_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // stage value bytes 0..63, fill the whole buffer with records so that no
    // byte is read before it is written, then end the list at offset 0
    no_idle = 1;
    for (int i = 0; i < 64; i++) send_item(K_STAGE, '0, '0, 10'(i), 8'($urandom()));
    for (int i = 0; i < 14; i++)
      send_item(K_ADD, 32'h1000_0000 + 32'(i), 16'd64, '0, '0);
    send_item(K_ADD, 32'h1000_00FF, 16'd38, '0, '0);
    for (int i = 0; i < 4; i++) send_item(K_LOAD, '0, '0, 10'(i), 8'hFF);
    send_item(K_VALIDATE, '0, '0, '0, '0);
    no_idle = 0;

    send_item(K_ADD, tag_pool[0], 16'd1, 10'h000, 8'h00);
    send_item(K_ADD, tag_pool[0], 16'd1, 10'h3FF, 8'hFF);
    send_item(K_ADD, tag_pool[1], 16'd0, 10'h000, 8'h00);
    send_item(K_ADD, tag_pool[1], 16'd257, 10'h000, 8'h00);
    send_item(K_ADD, tag_pool[1], 16'hFFFF, 10'h000, 8'h00);
    send_item(K_ADD, 32'hFFFF_FFFF, 16'd4, 10'h000, 8'h00);
    send_item(K_ADD, tag_pool[0], 16'd256, 10'h000, 8'h00);
    send_item(K_ADD, tag_pool[2], 16'd3, 10'h000, 8'h00);
    send_item(K_LOOKUP, tag_pool[0], 16'd0, 10'h000, 8'h00);
    send_item(K_LOOKUP, 32'h1234_5678, 16'd0, 10'h000, 8'h00);
    send_item(K_UPDATE, tag_pool[0], 16'd1, 10'h000, 8'h00);
    send_item(K_UPDATE, tag_pool[0], 16'd9, 10'h000, 8'h00);
    send_item(K_UPDATE, tag_pool[0], 16'd2, 10'h000, 8'h00);
    send_item(K_UPDATE, 32'h1234_5678, 16'd2, 10'h000, 8'h00);
    send_item(K_UPDATE, tag_pool[0], 16'd0, 10'h000, 8'h00);
    send_item(K_DELETE, tag_pool[3], 16'd0, 10'h000, 8'h00);
    send_item(K_DELETE, 32'h1234_5678, 16'd0, 10'h000, 8'h00);
    send_item(K_READ, '0, '0, 10'h000, 8'h00);
    send_item(K_READ, '0, '0, 10'h3FF, 8'h00);
    send_item(K_STAGE, '0, '0, 10'h3FF, 8'h00);
    send_item(K_LOAD, '0, '0, 10'h004, 8'hFF);
    send_item(K_LOOKUP, tag_pool[0], 16'd0, 10'h000, 8'h00);
    send_item(K_VALIDATE, '0, '0, 10'h000, 8'h00);
    send_item(K_LOOKUP, 32'hFFFF_FFFF, 16'd0, 10'h000, 8'h00);

    random_ops(60);
    write_reg(REG_CAPACITY, 32'($urandom_range(100, 400)));
    write_reg(REG_END_TAG, tag_pool[3]);
    send_item(K_VALIDATE, '0, '0, 10'h000, 8'h00);
    random_ops(50);
    write_reg(REG_CAPACITY, 32'd1);
    write_reg(REG_END_TAG, 32'h0000_0000);
    send_item(K_VALIDATE, '0, '0, 10'h000, 8'h00);
    random_ops(20);
    write_reg(REG_CAPACITY, 32'd2047);
    write_reg(REG_END_TAG, 32'hFFFF_FFFF);
    send_item(K_VALIDATE, '0, '0, 10'h000, 8'h00);
    random_ops(50);

    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("items sent %0d, responses checked %0d, over four register settings",
             sent, checked);
    if (errors == 0) $display("tlv_record_store_test: PASS");
    else $display("tlv_record_store_test: FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d responses outstanding", pending);
    $display("tlv_record_store_test: FAIL");
    $finish;
  end
endmodule
